@@ src/cce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cce_pkg: shared definitions of the Chebyshev series evaluator
// Field widths, fixed-point constants, sequencer states and the control
// bundle between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package cce_pkg;

    // default number of coefficient store entries
    localparam int MAX_TERMS_DEF = 16;

    // field widths
    localparam int KIND_W  = 1;
    localparam int INDEX_W = 4;
    localparam int COEFF_W = 18;
    localparam int POINT_W = 16;
    localparam int DEG_W   = 4;
    localparam int ACC_W   = 32;

    // fixed point: point is Q1.14, products drop 14 fraction bits
    localparam int FRAC_BITS = 14;

    // product of point and accumulator
    localparam int PROD_W = POINT_W + ACC_W;
    // exact width of one recurrence sum before saturation
    localparam int SUM_W  = ACC_W + 5;

    // accumulator limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_EVAL = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } seq_state_t;

    // controls from the sequencer to the arithmetic unit
    typedef struct packed {
        logic start;   // latch point, clear accumulators and flag
        logic mul;     // register point times b1
        logic acc;     // shift, add, saturate, shift b1 into b2
        logic last;    // final step: shift by 14 and write the result
    } step_ctrl_t;

endpackage
`default_nettype wire

@@ src/cce_coeff_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cce_coeff_store: coefficient store
// One write port for coefficient loads, one registered read port for the
// recurrence. Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module cce_coeff_store #(
    parameter int MAX_TERMS = cce_pkg::MAX_TERMS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                wr_en,
    input  wire logic [cce_pkg::INDEX_W-1:0]         wr_index,
    input  wire logic signed [cce_pkg::COEFF_W-1:0]  wr_data,
    input  wire logic                                rd_en,
    input  wire logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr,
    output logic signed [cce_pkg::COEFF_W-1:0]       rd_data
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int XW = (AW > cce_pkg::INDEX_W) ? AW : cce_pkg::INDEX_W;

    logic signed [cce_pkg::COEFF_W-1:0] mem [MAX_TERMS];
    logic [MAX_TERMS-1:0]               vld_reg;
    logic [MAX_TERMS-1:0]               vld_next;
    logic signed [cce_pkg::COEFF_W-1:0] rd_data_reg;

    logic [XW-1:0] idx_ext;
    logic          idx_in_range;
    logic [AW-1:0] wr_addr;

    // index range check, writes beyond the store are dropped
    always_comb begin
        idx_ext      = XW'(wr_index);
        idx_in_range = ({1'b0, idx_ext} < (XW+1)'(MAX_TERMS));
        wr_addr      = idx_ext[AW-1:0];
    end

    // valid bits
    always_comb begin
        vld_next = vld_reg;
        if (wr_en && idx_in_range) begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // storage array and registered read
    always_ff @(posedge aclk) begin
        if (wr_en && idx_in_range) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ src/cce_step_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cce_step_unit: shared Clenshaw step datapath
// One signed multiplier for point times b1, registered, then a floor shift,
// the add of c_k minus b2 and saturation to 32 bits. Holds b1, b2, the
// saturation flag and the result register.
// ----------------------------------------------------------------------------
module cce_step_unit (
    input  wire logic                                aclk,
    input  wire cce_pkg::step_ctrl_t                 ctrl,
    input  wire logic signed [cce_pkg::POINT_W-1:0]  point,
    input  wire logic signed [cce_pkg::COEFF_W-1:0]  coeff,
    output logic signed [cce_pkg::ACC_W-1:0]         res_value,
    output logic                                     res_saturated
);

    localparam int PW = cce_pkg::PROD_W;
    localparam int SW = cce_pkg::SUM_W;

    logic signed [cce_pkg::POINT_W-1:0] t_reg;
    logic signed [cce_pkg::ACC_W-1:0]   b1_reg;
    logic signed [cce_pkg::ACC_W-1:0]   b2_reg;
    logic signed [PW-1:0]               prod_reg;
    logic                               flag_reg;
    logic signed [cce_pkg::ACC_W-1:0]   res_value_reg;
    logic                               res_sat_reg;

    logic signed [PW-1:0]               prod_next;
    logic signed [PW-1:0]               shifted;
    logic signed [SW-1:0]               sum;
    logic signed [cce_pkg::ACC_W-1:0]   sum_sat;
    logic                               clip;

    // shared multiplier
    assign prod_next = PW'(t_reg) * PW'(b1_reg);

    // floor shift: doubled product in middle steps, plain product at the end
    always_comb begin
        if (ctrl.last) begin
            shifted = prod_reg >>> cce_pkg::FRAC_BITS;
        end else begin
            shifted = prod_reg >>> (cce_pkg::FRAC_BITS - 1);
        end
        sum = SW'(shifted) - SW'(b2_reg) + SW'(coeff);
    end

    // saturate to the accumulator range
    always_comb begin
        clip    = 1'b0;
        sum_sat = sum[cce_pkg::ACC_W-1:0];
        if (sum > SW'(cce_pkg::ACC_MAX)) begin
            clip    = 1'b1;
            sum_sat = cce_pkg::ACC_MAX;
        end else if (sum < SW'(cce_pkg::ACC_MIN)) begin
            clip    = 1'b1;
            sum_sat = cce_pkg::ACC_MIN;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            t_reg    <= point;
            b1_reg   <= '0;
            b2_reg   <= '0;
            flag_reg <= 1'b0;
        end else if (ctrl.acc) begin
            b2_reg   <= b1_reg;
            b1_reg   <= sum_sat;
            flag_reg <= flag_reg | clip;
        end
        if (ctrl.mul) begin
            prod_reg <= prod_next;
        end
        if (ctrl.acc && ctrl.last) begin
            res_value_reg <= sum_sat;
            res_sat_reg   <= flag_reg | clip;
        end
    end

    assign res_value     = res_value_reg;
    assign res_saturated = res_sat_reg;

endmodule
`default_nettype wire

@@ src/cce_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cce_seq: evaluator sequencer
// Takes requests, holds the degree register, counts k from the effective
// degree down to zero, drives store reads and the step unit, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module cce_seq #(
    parameter int MAX_TERMS = cce_pkg::MAX_TERMS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [cce_pkg::DEG_W-1:0]    cfg_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [cce_pkg::KIND_W-1:0]   s_kind,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              ld_en,
    output logic                              rd_en,
    output logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr,
    output cce_pkg::step_ctrl_t               ctrl
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int XW = (AW > cce_pkg::DEG_W) ? AW : cce_pkg::DEG_W;

    cce_pkg::seq_state_t          state_reg;
    cce_pkg::seq_state_t          state_next;
    logic [AW-1:0]                k_reg;
    logic [AW-1:0]                k_next;
    logic [cce_pkg::DEG_W-1:0]    degree_reg;
    logic [cce_pkg::DEG_W-1:0]    degree_next;
    logic                         m_valid_reg;
    logic                         m_valid_next;

    logic [XW-1:0]                deg_ext;
    logic [XW-1:0]                top_ext;
    logic                         out_free;

    // degree register, the user writes it only while idle; the block itself does not enforce it
    assign cfg_ready = 1'b1;

    always_comb begin
        degree_next = degree_reg;
        if (cfg_valid) begin
            degree_next = cfg_data;
        end
    end

    // effective degree clipped to the store size
    always_comb begin
        deg_ext = XW'(degree_reg);
        top_ext = deg_ext;
        if (deg_ext > XW'(MAX_TERMS - 1)) begin
            top_ext = XW'(MAX_TERMS - 1);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // next state and outputs
    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        ld_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = k_reg;
        ctrl         = '0;
        case (state_reg)
            cce_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == cce_pkg::KIND_EVAL) begin
                        ctrl.start = 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = top_ext[AW-1:0];
                        k_next     = top_ext[AW-1:0];
                        state_next = cce_pkg::ST_MUL;
                    end else begin
                        ld_en = 1'b1;
                    end
                end
            end
            cce_pkg::ST_MUL: begin
                ctrl.mul   = 1'b1;
                state_next = cce_pkg::ST_ACC;
            end
            cce_pkg::ST_ACC: begin
                ctrl.last = (k_reg == '0);
                if (k_reg != '0) begin
                    // middle step, fetch the next lower coefficient
                    ctrl.acc   = 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = k_reg - 1'b1;
                    k_next     = k_reg - 1'b1;
                    state_next = cce_pkg::ST_MUL;
                end else if (out_free) begin
                    // final step lands in the result register
                    ctrl.acc     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = cce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cce_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cce_pkg::ST_IDLE;
            k_reg       <= '0;
            degree_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            degree_reg  <= degree_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

@@ src/chebyshev_clenshaw_evaluator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chebyshev_clenshaw_evaluator_top: Chebyshev series evaluator
// Evaluates sum c_k * T_k(t) with the Clenshaw recurrence in fixed point.
// ----------------------------------------------------------------------------
// A load request (kind 0) writes one Q3.14 coefficient into the store;
// indexes at or beyond MAX_TERMS are dropped, and all entries read as zero
// after reset. An evaluate request (kind 1) runs the recurrence from the
// effective degree min(degree, MAX_TERMS-1) down to zero and returns one
// Q17.14 value with a saturation flag. Each recurrence step runs on the one
// shared multiplier, a product register in ST_MUL, then shift, add and
// saturate in ST_ACC, and s_ready stays low until the evaluate is done. The
// result sits in an output register, so the next request is taken while it
// waits; the user writes the degree register through the cfg channel only
// while the block is idle, and the block itself does not enforce it.
module chebyshev_clenshaw_evaluator_top #(
    parameter int MAX_TERMS = cce_pkg::MAX_TERMS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // degree register write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [cce_pkg::DEG_W-1:0]           cfg_data,
    // request channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [cce_pkg::KIND_W-1:0]          s_kind,
    input  wire logic [cce_pkg::INDEX_W-1:0]         s_coeff_index,
    input  wire logic signed [cce_pkg::COEFF_W-1:0]  s_coeff_value,
    input  wire logic signed [cce_pkg::POINT_W-1:0]  s_point,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [cce_pkg::ACC_W-1:0]         m_value,
    output logic                                     m_saturated
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    logic                               ld_en;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic signed [cce_pkg::COEFF_W-1:0] rd_data;
    cce_pkg::step_ctrl_t                ctrl;

    // sequencer
    cce_seq #(
        .MAX_TERMS (MAX_TERMS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .ld_en     (ld_en),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .ctrl      (ctrl)
    );

    // coefficient store
    cce_coeff_store #(
        .MAX_TERMS (MAX_TERMS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (ld_en),
        .wr_index (s_coeff_index),
        .wr_data  (s_coeff_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // shared arithmetic
    cce_step_unit u_step (
        .aclk          (aclk),
        .ctrl          (ctrl),
        .point         (s_point),
        .coeff         (rd_data),
        .res_value     (m_value),
        .res_saturated (m_saturated)
    );

endmodule
`default_nettype wire

@@ sim/tb_chebyshev_clenshaw_evaluator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chebyshev_clenshaw_evaluator_top: testbench of the Chebyshev evaluator
// Loads coefficients and evaluates the series at directed and random points
// over several degree settings, with random idling on both channels. A
// scoreboard keeps its own copy of the coefficients and the degree, predicts
// each series value and saturation flag, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_chebyshev_clenshaw_evaluator_top;

    localparam int EVAL_CYCLES   = 2 * cce_pkg::MAX_TERMS_DEF + 1;
    localparam int SETTLE_CYCLES = EVAL_CYCLES + 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 100;

    typedef struct {
        logic signed [cce_pkg::ACC_W-1:0] value;
        logic                             saturated;
    } series_result_t;

    // coefficient copy, degree copy and the queue of predicted series values
    class series_checker;
        logic signed [cce_pkg::COEFF_W-1:0] coeff_copy [cce_pkg::MAX_TERMS_DEF];
        logic [cce_pkg::DEG_W-1:0]          degree;
        series_result_t                     expected_sums [$];
        int                                 errors;

        function new();
            foreach (coeff_copy[i]) coeff_copy[i] = '0;
            degree = '0;
            errors = 0;
        endfunction

        function void set_degree(logic [cce_pkg::DEG_W-1:0] d);
            degree = d;
        endfunction

        // clip an exact sum to the accumulator range, noting any clipping
        function logic signed [cce_pkg::ACC_W-1:0] clip(longint s, inout bit flag);
            if (s > longint'(cce_pkg::ACC_MAX)) begin
                flag = 1'b1;
                return cce_pkg::ACC_MAX;
            end
            if (s < longint'(cce_pkg::ACC_MIN)) begin
                flag = 1'b1;
                return cce_pkg::ACC_MIN;
            end
            return s[cce_pkg::ACC_W-1:0];
        endfunction

        // a load updates the copy, an evaluate runs the recurrence
        function void note_request(logic [cce_pkg::KIND_W-1:0] kind,
                                   logic [cce_pkg::INDEX_W-1:0] idx,
                                   logic signed [cce_pkg::COEFF_W-1:0] cval,
                                   logic signed [cce_pkg::POINT_W-1:0] point);
            longint                           t;
            longint                           prod;
            longint                           sum;
            logic signed [cce_pkg::ACC_W-1:0] b1;
            logic signed [cce_pkg::ACC_W-1:0] b2;
            bit                               sat;
            int                               top;
            series_result_t                   r;
            if (kind == cce_pkg::KIND_LOAD) begin
                if (int'(idx) < cce_pkg::MAX_TERMS_DEF) coeff_copy[idx] = cval;
                return;
            end
            t   = point;
            b1  = '0;
            b2  = '0;
            sat = 1'b0;
            top = (int'(degree) > cce_pkg::MAX_TERMS_DEF - 1) ?
                  cce_pkg::MAX_TERMS_DEF - 1 : int'(degree);
            // middle steps use 2*t*b1
            for (int k = top; k >= 1; k--) begin
                prod = t * longint'(b1);
                sum  = ((2 * prod) >>> cce_pkg::FRAC_BITS) - longint'(b2)
                       + longint'(coeff_copy[k]);
                b2   = b1;
                b1   = clip(sum, sat);
            end
            // final step uses t*b1 and c0
            prod        = t * longint'(b1);
            sum         = (prod >>> cce_pkg::FRAC_BITS) - longint'(b2)
                          + longint'(coeff_copy[0]);
            r.value     = clip(sum, sat);
            r.saturated = sat;
            expected_sums = {expected_sums, r};
        endfunction

        function void check_result(logic signed [cce_pkg::ACC_W-1:0] value,
                                   logic saturated);
            series_result_t want;
            if (expected_sums.size() == 0) begin
                $error("result with no evaluate pending: value %0d saturated %0b",
                       value, saturated);
                errors++;
                return;
            end
            want = expected_sums.pop_front();
            if (value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, value);
                errors++;
            end
            if (saturated !== want.saturated) begin
                $error("saturated: expected %0b, got %0b", want.saturated, saturated);
                errors++;
            end
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [cce_pkg::DEG_W-1:0]           cfg_data = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [cce_pkg::KIND_W-1:0]          s_kind = cce_pkg::KIND_LOAD;
    logic [cce_pkg::INDEX_W-1:0]         s_coeff_index = '0;
    logic signed [cce_pkg::COEFF_W-1:0]  s_coeff_value = '0;
    logic signed [cce_pkg::POINT_W-1:0]  s_point = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic signed [cce_pkg::ACC_W-1:0]    m_value;
    logic                                m_saturated;

    series_checker sb;
    bit            calm = 1'b0;
    int            rx_hold_left = 0;
    int            rx_stall_left = 0;
    int unsigned   cycle_count;

    chebyshev_clenshaw_evaluator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_coeff_index (s_coeff_index),
        .s_coeff_value (s_coeff_value),
        .s_point       (s_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_saturated   (m_saturated)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // result receiver: long hold when asked, else random stall bursts
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_ready = 1'b0;
                rx_hold_left--;
            end else if (rx_stall_left > 0) begin
                m_ready = 1'b0;
                rx_stall_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                rx_stall_left = $urandom_range(0, 11);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_value, m_saturated);
    end

    // offer one request and hold it until taken
    task automatic send_request(input logic [cce_pkg::KIND_W-1:0] kind,
                                input logic [cce_pkg::INDEX_W-1:0] idx,
                                input logic signed [cce_pkg::COEFF_W-1:0] cval,
                                input logic signed [cce_pkg::POINT_W-1:0] point);
        @(negedge aclk);
        s_valid       = 1'b1;
        s_kind        = kind;
        s_coeff_index = idx;
        s_coeff_value = cval;
        s_point       = point;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, idx, cval, point);
    endtask

    // sender gap: drop s_valid and idle, n sets the length
    task automatic sender_gap(input int n);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // stop sending, wait for every pending result, then let the block settle
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_degree(input logic [cce_pkg::DEG_W-1:0] d);
        drain_results();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = d;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_degree(d);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stimulus
    initial begin
        logic [cce_pkg::DEG_W-1:0]          deg;
        logic signed [cce_pkg::COEFF_W-1:0] cval;
        logic signed [cce_pkg::POINT_W-1:0] pt;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // cleared store and reset degree give zero
        send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                     cce_pkg::COEFF_W'($urandom), 16'sh2000);

        // full degree, extreme coefficients at the ends of the store
        write_degree(4'd15);
        send_request(cce_pkg::KIND_LOAD, 4'd0, 18'sh1FFFF, cce_pkg::POINT_W'($urandom));
        send_request(cce_pkg::KIND_LOAD, 4'd15, 18'sh20000, cce_pkg::POINT_W'($urandom));
        send_request(cce_pkg::KIND_LOAD, 4'd5, 18'sh15555, cce_pkg::POINT_W'($urandom));
        send_request(cce_pkg::KIND_LOAD, 4'd10, 18'sh2AAAA, cce_pkg::POINT_W'($urandom));
        send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                     cce_pkg::COEFF_W'($urandom), 16'sh4000);
        send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                     cce_pkg::COEFF_W'($urandom), 16'shC000);
        send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                     cce_pkg::COEFF_W'($urandom), 16'sh0000);
        // points outside +-1.0, expected to clip
        send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                     cce_pkg::COEFF_W'($urandom), 16'sh7FFF);
        send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                     cce_pkg::COEFF_W'($urandom), 16'sh8000);

        // degree zero returns c0
        write_degree(4'd0);
        send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                     cce_pkg::COEFF_W'($urandom), 16'shC000);

        // random phases, each at its own degree
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       deg = 4'd15;
                1:       deg = 4'd0;
                2:       deg = 4'd1;
                3:       deg = 4'd8;
                NUM_PHASES - 1: deg = 4'd15;
                default: deg = cce_pkg::DEG_W'($urandom);
            endcase
            write_degree(deg);
            if (ph == NUM_PHASES - 1) calm = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (!calm && $urandom_range(0, 6) == 0) sender_gap($urandom_range(1, 12));
                // receiver holds off while requests keep coming
                if (ph == 2 && i == 30) rx_hold_left = 300;
                // sender waits for every result mid-phase
                if (ph == 3 && i == 50) drain_results();
                if ($urandom_range(0, 9) < 4) begin
                    if ($urandom_range(0, 7) == 0)
                        cval = ($urandom_range(0, 1) == 1) ? 18'sh1FFFF : 18'sh20000;
                    else
                        cval = cce_pkg::COEFF_W'($urandom);
                    send_request(cce_pkg::KIND_LOAD, cce_pkg::INDEX_W'($urandom), cval,
                                 cce_pkg::POINT_W'($urandom));
                end else begin
                    if ($urandom_range(0, 3) == 0)
                        pt = cce_pkg::POINT_W'($urandom);
                    else
                        pt = cce_pkg::POINT_W'(int'($urandom_range(0, 32768)) - 16384);
                    send_request(cce_pkg::KIND_EVAL, cce_pkg::INDEX_W'($urandom),
                                 cce_pkg::COEFF_W'($urandom), pt);
                end
            end
        end

        drain_results();
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/cce_pkg.sv
src/cce_coeff_store.sv
src/cce_step_unit.sv
src/cce_seq.sv
src/chebyshev_clenshaw_evaluator_top.sv
sim/tb_chebyshev_clenshaw_evaluator_top.sv
